>>> hw/rtl/mlpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlpt_pkg
// Shared constants, types and fixed-point helpers of the perceptron trainer.
// ----------------------------------------------------------------------------
package mlpt_pkg;

    localparam int INPUT_COUNT  = 2;
    localparam int HIDDEN_COUNT = 2;
    localparam int FRAC_BITS    = 24;

    localparam int NW = INPUT_COUNT * HIDDEN_COUNT;
    localparam int NP = NW + 2 * HIDDEN_COUNT + 1;
    localparam int NM = NW + HIDDEN_COUNT;

    localparam int PIDX_W = $clog2(NP);
    localparam int MIDX_W = $clog2(NM);
    localparam int J_W    = (HIDDEN_COUNT > 1) ? $clog2(HIDDEN_COUNT) : 1;
    localparam int K_W    = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;

    localparam int CFG_W     = 25;
    localparam int CFG_IDX_W = 2;
    localparam int MUL_W     = 33;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int SQ_W      = 2 * ((32 + FRAC_BITS) / 2);
    localparam int ROOT_W    = SQ_W / 2;
    localparam int DEN_W     = ((ROOT_W > CFG_W) ? ROOT_W : CFG_W) + 1;
    localparam int NUM_W     = CFG_W + 31;
    localparam int DCNT_W    = $clog2(NUM_W);

    localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_DECAY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_DECAY  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STABILIZER    = 2'd3;

    localparam logic [CFG_W-1:0] LR_RESET   = 25'd16777;
    localparam logic [CFG_W-1:0] FD_RESET   = 25'd15099494;
    localparam logic [CFG_W-1:0] SD_RESET   = 25'd16760439;
    localparam logic [CFG_W-1:0] STAB_RESET = 25'd1;

    localparam logic REQ_TRAIN = 1'b0;
    localparam logic REQ_LOAD  = 1'b1;

    localparam logic signed [MUL_W-1:0] ONE_Q = MUL_W'(64'd1 << FRAC_BITS);
    localparam logic signed [63:0] MAX_W = 64'sd2147483647;
    localparam logic signed [63:0] MIN_W = -64'sd2147483648;

    typedef logic signed [31:0]      word_t;
    typedef logic [CFG_W-1:0]        cfg_t;
    typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;

    function automatic word_t sat32(input logic signed [63:0] v);
        word_t r;
        if (v > MAX_W)
            r = 32'sh7FFFFFFF;
        else if (v < MIN_W)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic word_t qsat(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        s = p >>> FRAC_BITS;
        return sat32(s[63:0]);
    endfunction

    function automatic logic signed [63:0] sx64(input word_t v);
        return {{32{v[31]}}, v};
    endfunction

endpackage

>>> hw/rtl/mlpt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlpt_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface mlpt_sample_if;
    import mlpt_pkg::*;
    logic        valid;
    logic        ready;
    logic        req_type;
    word_t       feature_a;
    word_t       feature_b;
    word_t       target;
    logic [3:0]  param_index;
    word_t       param_value;

    modport source (output valid, req_type, feature_a, feature_b, target,
                     param_index, param_value, input ready);
    modport sink (input valid, req_type, feature_a, feature_b, target,
                   param_index, param_value, output ready);
endinterface

interface mlpt_result_if;
    logic        valid;
    logic        ready;
    logic [30:0] prediction;
    logic [30:0] loss;

    modport source (output valid, prediction, loss, input ready);
    modport sink (input valid, prediction, loss, output ready);
endinterface

>>> hw/rtl/mlp_train_step_momentum_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_train_step_momentum_unit
// Two-layer relu perceptron trainer in q8.24 with moment-based weight update.
// ----------------------------------------------------------------------------
// A load word is written in the idle state. A train word runs the forward pass,
// backprop and all updates on one shared 33x33 multiplier, a radix-4 square
// root unit and a radix-2 divider; the six moment-based weight updates run
// one after another, and no new word is accepted before the last one is
// through. The result word is held in an output register until taken; ready
// is low while a train word is worked on.
// ----------------------------------------------------------------------------
module mlp_train_step_momentum_unit (
    input  logic                     clk,
    input  logic                     rst_n,
    mlpt_sample_if.sink              sample,
    mlpt_result_if.source            result,
    input  logic                     cfg_we,
    input  mlpt_pkg::cfg_idx_t       cfg_index,
    input  mlpt_pkg::cfg_t           cfg_data
);
    import mlpt_pkg::*;

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_H_INIT = 5'd1;
    localparam logic [4:0] ST_H_MUL  = 5'd2;
    localparam logic [4:0] ST_H_ACC  = 5'd3;
    localparam logic [4:0] ST_H_END  = 5'd4;
    localparam logic [4:0] ST_O_INIT = 5'd5;
    localparam logic [4:0] ST_O_MUL  = 5'd6;
    localparam logic [4:0] ST_O_ACC  = 5'd7;
    localparam logic [4:0] ST_O_END  = 5'd8;
    localparam logic [4:0] ST_L_MUL  = 5'd9;
    localparam logic [4:0] ST_L_END  = 5'd10;
    localparam logic [4:0] ST_D_MUL  = 5'd11;
    localparam logic [4:0] ST_D_END  = 5'd12;
    localparam logic [4:0] ST_U_SET  = 5'd13;
    localparam logic [4:0] ST_M1     = 5'd14;
    localparam logic [4:0] ST_M2     = 5'd15;
    localparam logic [4:0] ST_M3     = 5'd16;
    localparam logic [4:0] ST_M4     = 5'd17;
    localparam logic [4:0] ST_M5     = 5'd18;
    localparam logic [4:0] ST_M6     = 5'd19;
    localparam logic [4:0] ST_M7     = 5'd20;
    localparam logic [4:0] ST_M8     = 5'd21;
    localparam logic [4:0] ST_M9     = 5'd22;
    localparam logic [4:0] ST_SQRT   = 5'd23;
    localparam logic [4:0] ST_DEN    = 5'd24;
    localparam logic [4:0] ST_DIVI   = 5'd25;
    localparam logic [4:0] ST_DIV    = 5'd26;
    localparam logic [4:0] ST_WB     = 5'd27;
    localparam logic [4:0] ST_B_MUL  = 5'd28;
    localparam logic [4:0] ST_B_END  = 5'd29;
    localparam logic [4:0] ST_DONE   = 5'd30;

    logic [4:0]  state_reg, state_next;
    cfg_t        lr_reg, lr_next, fd_reg, fd_next, sd_reg, sd_next, stab_reg, stab_next;
    word_t       param_reg [NP];
    word_t       param_next [NP];
    word_t       mom1_reg [NM];
    word_t       mom1_next [NM];
    word_t       mom2_reg [NM];
    word_t       mom2_next [NM];
    word_t       x_reg [INPUT_COUNT];
    word_t       x_next [INPUT_COUNT];
    word_t       hid_reg [HIDDEN_COUNT];
    word_t       hid_next [HIDDEN_COUNT];
    word_t       dhid_reg [HIDDEN_COUNT];
    word_t       dhid_next [HIDDEN_COUNT];
    word_t       target_reg, target_next, pred_reg, pred_next, dout_reg, dout_next;
    word_t       t1_reg, t1_next, t2_reg, t2_next, mnew_reg, mnew_next;
    word_t       vnew_reg, vnew_next, delta_reg, delta_next, act_reg, act_next;
    logic [30:0] loss_reg, loss_next;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [J_W-1:0]    j_reg, j_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic              is_out_reg, is_out_next;
    logic [PIDX_W-1:0] pidx_reg, pidx_next;
    logic [MIDX_W-1:0] midx_reg, midx_next;
    logic [SQ_W-1:0]   sq_rem_reg, sq_rem_next, sq_res_reg, sq_res_next;
    logic [SQ_W-1:0]   sq_bit_reg, sq_bit_next;
    logic [DEN_W-1:0]  den_reg, den_next, dv_rem_reg, dv_rem_next;
    logic [NUM_W-1:0]  dv_q_reg, dv_q_next;
    logic              dv_neg_reg, dv_neg_next;
    logic [DCNT_W-1:0] dv_cnt_reg, dv_cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic [30:0]       out_pred_reg, out_pred_next, out_loss_reg, out_loss_next;

    logic signed [MUL_W-1:0] mul_a, mul_b;
    word_t                   qv;
    logic                    last_j, last_k;

    assign qv     = qsat(prod_reg);
    assign last_j = (32'(j_reg) == HIDDEN_COUNT - 1);
    assign last_k = (32'(k_reg) == INPUT_COUNT - 1);

    assign sample.ready      = (state_reg == ST_IDLE);
    assign result.valid      = out_valid_reg;
    assign result.prediction = out_pred_reg;
    assign result.loss       = out_loss_reg;

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_H_MUL:
            begin
                mul_a = MUL_W'(x_reg[k_reg]);
                mul_b = MUL_W'(param_reg[PIDX_W'(32'(k_reg) * HIDDEN_COUNT + 32'(j_reg))]);
            end
            ST_O_MUL, ST_D_MUL:
            begin
                mul_a = (state_reg == ST_O_MUL) ? MUL_W'(hid_reg[j_reg]) : MUL_W'(dout_reg);
                mul_b = MUL_W'(param_reg[PIDX_W'(NW + HIDDEN_COUNT + 32'(j_reg))]);
            end
            ST_L_MUL:
            begin
                mul_a = $signed({pred_reg[31], pred_reg}) - $signed({target_reg[31], target_reg});
                if (mul_a < 0)
                    mul_a = -mul_a;
                mul_b = mul_a;
            end
            ST_M1:
            begin
                mul_a = $signed({8'd0, fd_reg});
                mul_b = MUL_W'(mom1_reg[midx_reg]);
            end
            ST_M2:
            begin
                mul_a = MUL_W'(delta_reg);
                mul_b = MUL_W'(act_reg);
            end
            ST_M4:
            begin
                mul_a = ONE_Q - $signed({8'd0, fd_reg});
                mul_b = MUL_W'(t2_reg);
            end
            ST_M5:
            begin
                mul_a = $signed({8'd0, sd_reg});
                mul_b = MUL_W'(mom2_reg[midx_reg]);
            end
            ST_M6:
            begin
                mul_a = MUL_W'(delta_reg);
                mul_b = MUL_W'(delta_reg);
            end
            ST_M8:
            begin
                mul_a = ONE_Q - $signed({8'd0, sd_reg});
                mul_b = MUL_W'(t2_reg);
            end
            ST_DEN:
            begin
                mul_a = $signed({8'd0, lr_reg});
                mul_b = MUL_W'(mnew_reg);
            end
            ST_B_MUL:
            begin
                mul_a = $signed({8'd0, lr_reg});
                mul_b = MUL_W'(delta_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        word_t                    s;
        logic signed [63:0]       wsum;
        logic signed [63:0]       step;
        logic signed [PROD_W-1:0] lsh;
        logic signed [PROD_W-1:0] pabs;
        logic [SQ_W-1:0]          sq_try;
        logic [DEN_W:0]           r2;
        logic [DEN_W:0]           dsum;
        logic                     ge;

        state_next     = state_reg;
        lr_next        = lr_reg;
        fd_next        = fd_reg;
        sd_next        = sd_reg;
        stab_next      = stab_reg;
        param_next     = param_reg;
        mom1_next      = mom1_reg;
        mom2_next      = mom2_reg;
        x_next         = x_reg;
        hid_next       = hid_reg;
        dhid_next      = dhid_reg;
        target_next    = target_reg;
        pred_next      = pred_reg;
        dout_next      = dout_reg;
        t1_next        = t1_reg;
        t2_next        = t2_reg;
        mnew_next      = mnew_reg;
        vnew_next      = vnew_reg;
        delta_next     = delta_reg;
        act_next       = act_reg;
        loss_next      = loss_reg;
        acc_next       = acc_reg;
        prod_next      = mul_a * mul_b;
        j_next         = j_reg;
        k_next         = k_reg;
        is_out_next    = is_out_reg;
        pidx_next      = pidx_reg;
        midx_next      = midx_reg;
        sq_rem_next    = sq_rem_reg;
        sq_res_next    = sq_res_reg;
        sq_bit_next    = sq_bit_reg;
        den_next       = den_reg;
        dv_rem_next    = dv_rem_reg;
        dv_q_next      = dv_q_reg;
        dv_neg_next    = dv_neg_reg;
        dv_cnt_next    = dv_cnt_reg;
        out_valid_next = out_valid_reg;
        out_pred_next  = out_pred_reg;
        out_loss_next  = out_loss_reg;
        s      = '0;
        wsum   = '0;
        step   = '0;
        lsh    = '0;
        pabs   = '0;
        sq_try = '0;
        r2     = '0;
        dsum   = '0;
        ge     = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_LEARNING_RATE: lr_next   = cfg_data;
                REG_FIRST_DECAY:   fd_next   = cfg_data;
                REG_SECOND_DECAY:  sd_next   = cfg_data;
                REG_STABILIZER:    stab_next = cfg_data;
                default:           lr_next   = lr_reg;
            endcase
        end

        if (result.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (sample.valid)
                begin
                    if (sample.req_type == REQ_LOAD)
                    begin
                        if (32'(sample.param_index) < NP)
                            param_next[PIDX_W'(sample.param_index)] = sample.param_value;
                    end
                    else
                    begin
                        for (int k = 0; k < INPUT_COUNT; k++)
                            x_next[k] = (k == 0) ? sample.feature_a :
                                        (k == 1) ? sample.feature_b : '0;
                        target_next = sample.target;
                        j_next      = '0;
                        state_next  = ST_H_INIT;
                    end
                end
            end
            ST_H_INIT:
            begin
                acc_next   = sx64(param_reg[PIDX_W'(NW + 32'(j_reg))]);
                k_next     = '0;
                state_next = ST_H_MUL;
            end
            ST_H_MUL:
                state_next = ST_H_ACC;
            ST_H_ACC:
            begin
                acc_next = acc_reg + sx64(qv);
                if (last_k)
                    state_next = ST_H_END;
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_H_MUL;
                end
            end
            ST_H_END:
            begin
                s = sat32(acc_reg);
                hid_next[j_reg] = (s > 0) ? s : '0;
                if (last_j)
                    state_next = ST_O_INIT;
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_H_INIT;
                end
            end
            ST_O_INIT:
            begin
                acc_next   = sx64(param_reg[PIDX_W'(NP - 1)]);
                j_next     = '0;
                state_next = ST_O_MUL;
            end
            ST_O_MUL:
                state_next = ST_O_ACC;
            ST_O_ACC:
            begin
                acc_next = acc_reg + sx64(qv);
                if (last_j)
                    state_next = ST_O_END;
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_O_MUL;
                end
            end
            ST_O_END:
            begin
                s          = sat32(acc_reg);
                pred_next  = (s > 0) ? s : '0;
                state_next = ST_L_MUL;
            end
            ST_L_MUL:
            begin
                dout_next  = (pred_reg > 0) ? sat32(sx64(target_reg) - sx64(pred_reg)) : '0;
                j_next     = '0;
                state_next = ST_L_END;
            end
            ST_L_END:
            begin
                lsh = prod_reg >>> (FRAC_BITS + 1);
                loss_next  = (lsh > PROD_W'(MAX_W)) ? 31'h7FFFFFFF : lsh[30:0];
                state_next = ST_D_MUL;
            end
            ST_D_MUL:
                state_next = ST_D_END;
            ST_D_END:
            begin
                dhid_next[j_reg] = (hid_reg[j_reg] > 0) ? qv : '0;
                if (last_j)
                begin
                    is_out_next = 1'b1;
                    j_next      = '0;
                    k_next      = '0;
                    state_next  = ST_U_SET;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_D_MUL;
                end
            end
            ST_U_SET:
            begin
                if (is_out_reg)
                begin
                    delta_next = dout_reg;
                    act_next   = hid_reg[j_reg];
                    pidx_next  = PIDX_W'(NW + HIDDEN_COUNT + 32'(j_reg));
                    midx_next  = MIDX_W'(NW + 32'(j_reg));
                end
                else
                begin
                    delta_next = dhid_reg[j_reg];
                    act_next   = x_reg[k_reg];
                    pidx_next  = PIDX_W'(32'(k_reg) * HIDDEN_COUNT + 32'(j_reg));
                    midx_next  = MIDX_W'(32'(k_reg) * HIDDEN_COUNT + 32'(j_reg));
                end
                state_next = ST_M1;
            end
            ST_M1:
                state_next = ST_M2;
            ST_M2:
            begin
                t1_next    = qv;
                state_next = ST_M3;
            end
            ST_M3:
            begin
                t2_next    = qv;
                state_next = ST_M4;
            end
            ST_M4:
                state_next = ST_M5;
            ST_M5:
            begin
                mnew_next  = sat32(sx64(t1_reg) + sx64(qv));
                state_next = ST_M6;
            end
            ST_M6:
            begin
                t1_next    = qv;
                state_next = ST_M7;
            end
            ST_M7:
            begin
                t2_next    = qv;
                state_next = ST_M8;
            end
            ST_M8:
                state_next = ST_M9;
            ST_M9:
            begin
                s           = sat32(sx64(t1_reg) + sx64(qv));
                vnew_next   = s;
                sq_rem_next = (s > 0) ? (SQ_W'(s[30:0]) << FRAC_BITS) : '0;
                sq_res_next = '0;
                sq_bit_next = SQ_W'(1) << (SQ_W - 2);
                state_next  = ST_SQRT;
            end
            ST_SQRT:
            begin
                sq_try = sq_res_reg + sq_bit_reg;
                if (sq_rem_reg >= sq_try)
                begin
                    sq_rem_next = sq_rem_reg - sq_try;
                    sq_res_next = (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                    sq_res_next = sq_res_reg >> 1;
                sq_bit_next = sq_bit_reg >> 2;
                if (sq_bit_reg[0])
                    state_next = ST_DEN;
            end
            ST_DEN:
            begin
                dsum = (DEN_W + 1)'(sq_res_reg[ROOT_W-1:0]) + (DEN_W + 1)'(stab_reg);
                den_next   = (dsum == '0) ? DEN_W'(1) : dsum[DEN_W-1:0];
                state_next = ST_DIVI;
            end
            ST_DIVI:
            begin
                dv_neg_next = prod_reg[PROD_W-1];
                pabs        = prod_reg[PROD_W-1] ? -prod_reg : prod_reg;
                dv_q_next   = pabs[NUM_W-1:0];
                dv_rem_next = '0;
                dv_cnt_next = '0;
                state_next  = ST_DIV;
            end
            ST_DIV:
            begin
                r2 = {dv_rem_reg, dv_q_reg[NUM_W-1]};
                ge = (r2 >= {1'b0, den_reg});
                dv_rem_next = ge ? DEN_W'(r2 - {1'b0, den_reg}) : r2[DEN_W-1:0];
                dv_q_next   = {dv_q_reg[NUM_W-2:0], ge};
                dv_cnt_next = dv_cnt_reg + 1'b1;
                if (32'(dv_cnt_reg) == NUM_W - 1)
                    state_next = ST_WB;
            end
            ST_WB:
            begin
                step = 64'(dv_q_reg);
                if (dv_neg_reg)
                    step = -step;
                wsum = sx64(param_reg[pidx_reg]) + step;
                param_next[pidx_reg] = sat32(wsum);
                mom1_next[midx_reg]  = mnew_reg;
                mom2_next[midx_reg]  = vnew_reg;
                if (is_out_reg)
                begin
                    if (last_j)
                    begin
                        delta_next = dout_reg;
                        pidx_next  = PIDX_W'(NP - 1);
                        state_next = ST_B_MUL;
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_U_SET;
                    end
                end
                else
                begin
                    if (last_k)
                    begin
                        delta_next = dhid_reg[j_reg];
                        pidx_next  = PIDX_W'(NW + 32'(j_reg));
                        state_next = ST_B_MUL;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_U_SET;
                    end
                end
            end
            ST_B_MUL:
                state_next = ST_B_END;
            ST_B_END:
            begin
                param_next[pidx_reg] = sat32(sx64(param_reg[pidx_reg]) + sx64(qv));
                if (is_out_reg)
                begin
                    is_out_next = 1'b0;
                    j_next      = '0;
                    k_next      = '0;
                    state_next  = ST_U_SET;
                end
                else if (last_j)
                    state_next = ST_DONE;
                else
                begin
                    j_next     = j_reg + 1'b1;
                    k_next     = '0;
                    state_next = ST_U_SET;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_pred_next  = pred_reg[30:0];
                    out_loss_next  = loss_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control, configuration and trained state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            lr_reg        <= LR_RESET;
            fd_reg        <= FD_RESET;
            sd_reg        <= SD_RESET;
            stab_reg      <= STAB_RESET;
            is_out_reg    <= 1'b0;
            j_reg         <= '0;
            k_reg         <= '0;
            dv_cnt_reg    <= '0;
            for (int i = 0; i < NP; i++)
                param_reg[i] <= '0;
            for (int i = 0; i < NM; i++)
            begin
                mom1_reg[i] <= '0;
                mom2_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            lr_reg        <= lr_next;
            fd_reg        <= fd_next;
            sd_reg        <= sd_next;
            stab_reg      <= stab_next;
            is_out_reg    <= is_out_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            dv_cnt_reg    <= dv_cnt_next;
            param_reg     <= param_next;
            mom1_reg      <= mom1_next;
            mom2_reg      <= mom2_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        hid_reg      <= hid_next;
        dhid_reg     <= dhid_next;
        target_reg   <= target_next;
        pred_reg     <= pred_next;
        dout_reg     <= dout_next;
        t1_reg       <= t1_next;
        t2_reg       <= t2_next;
        mnew_reg     <= mnew_next;
        vnew_reg     <= vnew_next;
        delta_reg    <= delta_next;
        act_reg      <= act_next;
        loss_reg     <= loss_next;
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        pidx_reg     <= pidx_next;
        midx_reg     <= midx_next;
        sq_rem_reg   <= sq_rem_next;
        sq_res_reg   <= sq_res_next;
        sq_bit_reg   <= sq_bit_next;
        den_reg      <= den_next;
        dv_rem_reg   <= dv_rem_next;
        dv_q_reg     <= dv_q_next;
        dv_neg_reg   <= dv_neg_next;
        out_pred_reg <= out_pred_next;
        out_loss_reg <= out_loss_next;
    end

endmodule

>>> test/tb_mlp_train_step_momentum_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mlp_train_step_momentum_unit
// Self-checking bench for the perceptron trainer: load and train words are
// driven with random idle bursts, each train word is predicted by a software
// copy of the network and its moment state, and every result word is compared
// in order against the oldest predicted prediction and loss.
// ----------------------------------------------------------------------------
module tb_mlp_train_step_momentum_unit;
    import mlpt_pkg::*;

    typedef struct packed {
        logic        req_type;
        word_t       feature_a;
        word_t       feature_b;
        word_t       target;
        logic [3:0]  param_index;
        word_t       param_value;
    } request_t;

    typedef struct packed {
        logic [30:0] prediction;
        logic [30:0] loss;
    } outcome_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    cfg_idx_t cfg_index;
    cfg_t cfg_data;

    mlpt_sample_if sample ();
    mlpt_result_if result ();

    mlp_train_step_momentum_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample.sink),
        .result    (result.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    request_t pending_words[$];
    outcome_t expected_outcomes[$];
    int       errors;
    bit       quiet_tail;
    int       send_idle;
    int       recv_idle;

    longint rate, fdecay, sdecay, stab;
    longint hw[NW];
    longint hb[HIDDEN_COUNT];
    longint ow[HIDDEN_COUNT];
    longint obias;
    longint hm1[NW];
    longint hm2[NW];
    longint om1[HIDDEN_COUNT];
    longint om2[HIDDEN_COUNT];

    localparam longint QONE = longint'(1) << FRAC_BITS;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint fxmul(longint a, longint b);
        return clamp32((a * b) >>> FRAC_BITS);
    endfunction

    function automatic longint root64(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    task automatic adapt_weight(inout longint w, inout longint m, inout longint v,
                                input longint delta, input longint act);
        longint rt;
        longint den;
        m = clamp32(fxmul(fdecay, m) + fxmul(QONE - fdecay, fxmul(delta, act)));
        v = clamp32(fxmul(sdecay, v) + fxmul(QONE - sdecay, fxmul(delta, delta)));
        rt = (v > 0) ? root64(longint'(v) << FRAC_BITS) : 0;
        den = rt + stab;
        if (den == 0)
            den = 1;
        w = clamp32(w + (rate * m) / den);
    endtask

    task automatic predict_word(input request_t rq);
        longint x[INPUT_COUNT];
        longint hid[HIDDEN_COUNT];
        longint dh[HIDDEN_COUNT];
        longint acc, pred, tgt, dout, diff;
        longint unsigned mag, ls;
        int n;
        outcome_t o;
        if (rq.req_type == REQ_LOAD)
        begin
            if (rq.param_index < NW)
                hw[rq.param_index] = rq.param_value;
            else if (rq.param_index < NW + HIDDEN_COUNT)
                hb[rq.param_index - NW] = rq.param_value;
            else if (rq.param_index < NW + 2 * HIDDEN_COUNT)
                ow[rq.param_index - NW - HIDDEN_COUNT] = rq.param_value;
            else if (rq.param_index == NW + 2 * HIDDEN_COUNT)
                obias = rq.param_value;
            return;
        end
        x[0] = rq.feature_a;
        x[1] = rq.feature_b;
        tgt = rq.target;
        for (int j = 0; j < HIDDEN_COUNT; j++)
        begin
            acc = hb[j];
            for (int k = 0; k < INPUT_COUNT; k++)
                acc += fxmul(x[k], hw[k * HIDDEN_COUNT + j]);
            acc = clamp32(acc);
            hid[j] = acc > 0 ? acc : 0;
        end
        acc = obias;
        for (int j = 0; j < HIDDEN_COUNT; j++)
            acc += fxmul(hid[j], ow[j]);
        acc = clamp32(acc);
        pred = acc > 0 ? acc : 0;
        diff = pred - tgt;
        mag = diff < 0 ? -diff : diff;
        ls = (mag * mag) >> (FRAC_BITS + 1);
        if (ls > 64'd2147483647)
            ls = 64'd2147483647;
        dout = pred > 0 ? clamp32(tgt - pred) : 0;
        for (int j = 0; j < HIDDEN_COUNT; j++)
            dh[j] = hid[j] > 0 ? fxmul(dout, ow[j]) : 0;
        for (int j = 0; j < HIDDEN_COUNT; j++)
            adapt_weight(ow[j], om1[j], om2[j], dout, hid[j]);
        obias = clamp32(obias + fxmul(rate, dout));
        for (int j = 0; j < HIDDEN_COUNT; j++)
        begin
            for (int k = 0; k < INPUT_COUNT; k++)
            begin
                n = k * HIDDEN_COUNT + j;
                adapt_weight(hw[n], hm1[n], hm2[n], dh[j], x[k]);
            end
            hb[j] = clamp32(hb[j] + fxmul(rate, dh[j]));
        end
        o.prediction = pred[30:0];
        o.loss = ls[30:0];
        expected_outcomes.push_back(o);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample.valid <= 1'b0;
            send_idle <= 0;
        end
        else
        begin
            if (sample.valid && sample.ready)
            begin
                predict_word(pending_words.pop_front());
            end
            if (sample.valid && !sample.ready)
            begin
            end
            else if (send_idle > 0)
            begin
                sample.valid <= 1'b0;
                send_idle <= send_idle - 1;
            end
            else if (pending_words.size() > 0 && !(sample.valid && sample.ready
                     && pending_words.size() == 0))
            begin
                if (!quiet_tail && $urandom_range(0, 5) == 0)
                begin
                    sample.valid <= 1'b0;
                    send_idle <= $urandom_range(0, 3);
                end
                else
                begin
                    sample.valid <= 1'b1;
                    {sample.req_type, sample.feature_a, sample.feature_b, sample.target,
                     sample.param_index, sample.param_value} <= pending_words[0];
                end
            end
            else
                sample.valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result.ready <= 1'b0;
            recv_idle <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    $error("unexpected result word");
                    errors++;
                end
                else
                begin
                    outcome_t e;
                    e = expected_outcomes.pop_front();
                    if (result.prediction !== e.prediction)
                    begin
                        $error("prediction expected %0d actual %0d", e.prediction,
                               result.prediction);
                        errors++;
                    end
                    if (result.loss !== e.loss)
                    begin
                        $error("loss expected %0d actual %0d", e.loss, result.loss);
                        errors++;
                    end
                end
            end
            if (recv_idle > 0)
            begin
                result.ready <= 1'b0;
                recv_idle <= recv_idle - 1;
            end
            else if (!quiet_tail && $urandom_range(0, 4) == 0)
            begin
                result.ready <= 1'b0;
                recv_idle <= $urandom_range(0, 3);
            end
            else
                result.ready <= 1'b1;
        end
    end

    function automatic request_t load_word(int idx, word_t val);
        request_t r;
        r = '0;
        r.req_type = REQ_LOAD;
        r.param_index = idx[3:0];
        r.param_value = val;
        r.feature_a = $urandom;
        r.target = $urandom;
        return r;
    endfunction

    function automatic request_t train_word(word_t a, word_t b, word_t t);
        request_t r;
        r = '0;
        r.req_type = REQ_TRAIN;
        r.feature_a = a;
        r.feature_b = b;
        r.target = t;
        r.param_index = 4'($urandom);
        r.param_value = $urandom;
        return r;
    endfunction

    function automatic word_t rand_small();
        return $signed($urandom_range(0, 8 << FRAC_BITS)) - (4 << FRAC_BITS);
    endfunction

    function automatic word_t rand_any();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'sh7FFFFFFF;
            2: return 32'sh80000000;
            default: return rand_small();
        endcase
    endfunction

    task automatic drain();
        while (pending_words.size() > 0 || expected_outcomes.size() > 0 || sample.valid)
            @(posedge clk);
        repeat (700) @(posedge clk);
    endtask

    task automatic set_reg(cfg_idx_t idx, cfg_t val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_LEARNING_RATE: rate = val;
            REG_FIRST_DECAY: fdecay = val;
            REG_SECOND_DECAY: sdecay = val;
            default: stab = val;
        endcase
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                pending_words.push_back(load_word($urandom_range(0, 15), rand_any()));
            else
                pending_words.push_back(train_word(rand_any(), rand_any(), rand_any()));
        end
    endtask

    initial
    begin
        errors = 0;
        quiet_tail = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_LEARNING_RATE;
        cfg_data = '0;
        sample.valid = 1'b0;
        sample.req_type = REQ_TRAIN;
        sample.feature_a = '0;
        sample.feature_b = '0;
        sample.target = '0;
        sample.param_index = '0;
        sample.param_value = '0;
        result.ready = 1'b0;
        rate = LR_RESET;
        fdecay = FD_RESET;
        sdecay = SD_RESET;
        stab = STAB_RESET;
        for (int i = 0; i < NW; i++)
        begin
            hw[i] = 0;
            hm1[i] = 0;
            hm2[i] = 0;
        end
        for (int j = 0; j < HIDDEN_COUNT; j++)
        begin
            hb[j] = 0;
            ow[j] = 0;
            om1[j] = 0;
            om2[j] = 0;
        end
        obias = 0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset defaults, extremes, all indexes including ignored ones
        pending_words.push_back(train_word(32'sh01000000, 32'sh01000000, 32'sh01000000));
        for (int i = 0; i <= NP; i++)
            pending_words.push_back(load_word(i, 32'sh00800000 + i * 32'sh00100000));
        pending_words.push_back(load_word(15, 32'sh7FFFFFFF));
        pending_words.push_back(train_word(32'sh01000000, 32'sh02000000, 32'sh03000000));
        pending_words.push_back(train_word(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000));
        pending_words.push_back(train_word(32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF));
        pending_words.push_back(train_word(32'sh80000000, 32'sh7FFFFFFF, 32'sh00000000));
        pending_words.push_back(train_word(32'shFFFFFFFF, 32'sh00000001, 32'shFFFFFFFF));
        pending_words.push_back(load_word(NP - 1, 32'sh80000000));
        pending_words.push_back(train_word(32'sh01000000, 32'sh01000000, 32'sh00000000));
        drain();

        // extremes: rate one, decays above one, zero stabilizer
        set_reg(REG_LEARNING_RATE, 25'h1000000);
        set_reg(REG_FIRST_DECAY, 25'h1FFFFFF);
        set_reg(REG_SECOND_DECAY, 25'h1FFFFFF);
        set_reg(REG_STABILIZER, 25'd0);
        random_phase(200);
        drain();

        set_reg(REG_LEARNING_RATE, 25'd0);
        set_reg(REG_FIRST_DECAY, 25'd0);
        set_reg(REG_SECOND_DECAY, 25'd0);
        set_reg(REG_STABILIZER, 25'h1000000);
        random_phase(200);
        drain();

        for (int p = 0; p < 4; p++)
        begin
            set_reg(REG_LEARNING_RATE, cfg_t'($urandom));
            set_reg(REG_FIRST_DECAY, cfg_t'($urandom));
            set_reg(REG_SECOND_DECAY, cfg_t'($urandom));
            set_reg(REG_STABILIZER, cfg_t'($urandom));
            if (p == 3)
                quiet_tail = 1'b1;
            random_phase(220);
            drain();
        end

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/mlpt_pkg.sv
hw/rtl/mlpt_if.sv
hw/rtl/mlp_train_step_momentum_unit.sv
test/tb_mlp_train_step_momentum_unit.sv
